### rtl/core/falc_pkg.sv
package falc_pkg;

  // fixed field widths of the channels and the config register
  localparam int unsigned LOOKUP_TAG_W = 32;
  localparam int unsigned LINE_USED_W  = 4;
  localparam int unsigned CNT_W        = 32;
  localparam int unsigned CFG_W        = 5;

  // active line count after reset
  localparam logic [CFG_W-1:0] ACTIVE_BLOCKS_RST = 5'd16;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_tag;
    logic lookup;
    logic scan_step;
    logic commit;
  } falc_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic found;
    logic single_line;
    logic scan_last;
    logic out_stall;
  } falc_status_t;

endpackage

### rtl/core/falc_lookup_if.sv
interface falc_lookup_if
  import falc_pkg::*;
();

  logic                    valid;
  logic                    ready;
  logic [LOOKUP_TAG_W-1:0] lookup_tag;

  modport source (output valid, output lookup_tag, input ready);
  modport sink   (input valid, input lookup_tag, output ready);

endinterface

### rtl/core/falc_result_if.sv
interface falc_result_if
  import falc_pkg::*;
();

  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic [LINE_USED_W-1:0]  line_used;
  logic                    evicted;
  logic [LOOKUP_TAG_W-1:0] evicted_tag;
  logic [CNT_W-1:0]        hit_total;
  logic [CNT_W-1:0]        miss_total;

  modport source (
    output valid, output hit, output line_used, output evicted,
    output evicted_tag, output hit_total, output miss_total,
    input ready
  );
  modport sink (
    input valid, input hit, input line_used, input evicted,
    input evicted_tag, input hit_total, input miss_total,
    output ready
  );

endinterface

### rtl/core/falc_ctrl.sv
module falc_ctrl
  import falc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  falc_status_t status_i,
  output falc_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN,
    ST_COMMIT
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // commands decoded from the current state, the input handshake and the output stall
  always_comb begin
    cmd_o           = '0;
    cmd_o.load_tag  = accept;
    cmd_o.lookup    = (state_q == ST_LOOKUP);
    cmd_o.scan_step = (state_q == ST_SCAN);
    cmd_o.commit    = (state_q == ST_COMMIT) && !status_i.out_stall;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (status_i.found || status_i.single_line) state_d = ST_COMMIT;
        else                                         state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (status_i.scan_last) state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (!status_i.out_stall) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/core/falc_datapath.sv
module falc_datapath
  import falc_pkg::*;
#(
  parameter int unsigned NUM_LINES = 16,
  parameter int unsigned TAG_BITS  = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [CFG_W-1:0]        active_blocks_i,
  input  logic [LOOKUP_TAG_W-1:0] lookup_tag_i,
  input  falc_cmd_t               cmd_i,
  output falc_status_t            status_o,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic                    res_hit_o,
  output logic [LINE_USED_W-1:0]  res_line_used_o,
  output logic                    res_evicted_o,
  output logic [LOOKUP_TAG_W-1:0] res_evicted_tag_o,
  output logic [CNT_W-1:0]        res_hit_total_o,
  output logic [CNT_W-1:0]        res_miss_total_o
);

  localparam int unsigned LINE_W = $clog2(NUM_LINES);
  localparam int unsigned N_W    = $clog2(NUM_LINES + 1);
  localparam int unsigned AB_W   = (N_W > CFG_W) ? N_W : CFG_W;
  localparam int unsigned IN_CP  = (TAG_BITS < LOOKUP_TAG_W) ? TAG_BITS : LOOKUP_TAG_W;
  localparam int unsigned LU_CP  = (LINE_W < LINE_USED_W) ? LINE_W : LINE_USED_W;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  // line storage
  logic [NUM_LINES-1:0] line_valid_q;
  logic [TAG_BITS-1:0]  line_tag_q   [NUM_LINES];
  logic [CNT_W-1:0]     line_stamp_q [NUM_LINES];

  logic [CNT_W-1:0]    access_clock_q, hits_q, misses_q;
  logic [TAG_BITS-1:0] tag_q, tag_in;
  logic                hit_q, free_q;
  logic [LINE_W-1:0]   line_q, scan_idx_q;
  logic [CNT_W-1:0]    best_stamp_q;

  logic                    out_valid_q;
  logic                    res_hit_q, res_evicted_q;
  logic [LINE_USED_W-1:0]  res_line_q;
  logic [LOOKUP_TAG_W-1:0] res_evicted_tag_q;
  logic [CNT_W-1:0]        res_hit_total_q, res_miss_total_q;

  logic [AB_W-1:0]      ab_ext, n_full;
  logic [LINE_W-1:0]    last_idx;
  logic [NUM_LINES-1:0] active, match, free;
  logic                 hit_any, free_any;
  logic [LINE_W-1:0]    hit_idx, free_idx;
  logic                 evict;
  logic [CNT_W-1:0]     hits_d, misses_d;
  logic [LINE_USED_W-1:0]  line_out;
  logic [LOOKUP_TAG_W-1:0] ev_tag_out;

  // incoming tag trimmed or widened to the stored tag width
  always_comb begin
    tag_in            = '0;
    tag_in[IN_CP-1:0] = lookup_tag_i[IN_CP-1:0];
  end

  // clamp the active line count into 1 .. NUM_LINES
  assign ab_ext = AB_W'(active_blocks_i);
  always_comb begin
    if (ab_ext == '0)                        n_full = AB_W'(1);
    else if (ab_ext > AB_W'(NUM_LINES))      n_full = AB_W'(NUM_LINES);
    else                                     n_full = ab_ext;
  end
  assign last_idx = LINE_W'(n_full - AB_W'(1));

  // parallel tag compare and free line detect
  always_comb begin
    for (int i = 0; i < NUM_LINES; i++) begin
      active[i] = (LINE_W'(i) <= last_idx);
      match[i]  = active[i] && line_valid_q[i] && (line_tag_q[i] == tag_q);
      free[i]   = active[i] && !line_valid_q[i];
    end
  end

  // lowest index priority encoders
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = NUM_LINES - 1; i >= 0; i--) begin
      if (match[i]) hit_idx  = LINE_W'(i);
      if (free[i])  free_idx = LINE_W'(i);
    end
  end
  assign hit_any  = |match;
  assign free_any = |free;

  assign status_o.found       = hit_any || free_any;
  assign status_o.single_line = (last_idx == '0);
  assign status_o.scan_last   = (scan_idx_q == last_idx);
  assign status_o.out_stall   = out_valid_q && !out_ready_i;

  // lookup result and the sequential minimum stamp search
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_tag) tag_q <= tag_in;
    if (cmd_i.lookup) begin
      hit_q        <= hit_any;
      free_q       <= free_any;
      best_stamp_q <= line_stamp_q[0];
      scan_idx_q   <= LINE_W'(1);
      if (hit_any)       line_q <= hit_idx;
      else if (free_any) line_q <= free_idx;
      else               line_q <= '0;
    end else if (cmd_i.scan_step) begin
      if (line_stamp_q[scan_idx_q] < best_stamp_q) begin
        best_stamp_q <= line_stamp_q[scan_idx_q];
        line_q       <= scan_idx_q;
      end
      scan_idx_q <= scan_idx_q + 1'b1;
    end
  end

  // values taken at commit
  assign evict    = !hit_q && !free_q;
  assign hits_d   = hit_q ? sat_inc(hits_q) : hits_q;
  assign misses_d = hit_q ? misses_q : sat_inc(misses_q);
  always_comb begin
    line_out              = '0;
    line_out[LU_CP-1:0]   = line_q[LU_CP-1:0];
    ev_tag_out            = '0;
    if (evict) ev_tag_out[IN_CP-1:0] = line_tag_q[line_q][IN_CP-1:0];
  end

  // line update, counters and valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_valid_q   <= '0;
      access_clock_q <= '0;
      hits_q         <= '0;
      misses_q       <= '0;
      out_valid_q    <= 1'b0;
      for (int i = 0; i < NUM_LINES; i++) line_stamp_q[i] <= '0;
    end else begin
      if (cmd_i.commit) begin
        line_valid_q[line_q] <= 1'b1;
        line_stamp_q[line_q] <= access_clock_q;
        access_clock_q       <= sat_inc(access_clock_q);
        hits_q               <= hits_d;
        misses_q             <= misses_d;
        out_valid_q          <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // tag store and output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      line_tag_q[line_q] <= tag_q;
      res_hit_q          <= hit_q;
      res_line_q         <= line_out;
      res_evicted_q      <= evict;
      res_evicted_tag_q  <= ev_tag_out;
      res_hit_total_q    <= hits_d;
      res_miss_total_q   <= misses_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign res_hit_o         = res_hit_q;
  assign res_line_used_o   = res_line_q;
  assign res_evicted_o     = res_evicted_q;
  assign res_evicted_tag_o = res_evicted_tag_q;
  assign res_hit_total_o   = res_hit_total_q;
  assign res_miss_total_o  = res_miss_total_q;

  // committed line is valid afterwards
  a_commit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> line_valid_q[$past(line_q)])
    else $error("committed line not valid");

  // a commit never overwrites a result still held by the receiver
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> !(out_valid_q && !out_ready_i))
    else $error("result overwritten while stalled");

  // a hit never reports an eviction
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> !(res_hit_q && res_evicted_q))
    else $error("hit reported with eviction");

  // exactly one of the totals moves per commit unless saturated
  a_totals_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> (hits_q != $past(hits_q)) || (misses_q != $past(misses_q))
                     || ($past(hits_q) == CNT_MAX) || ($past(misses_q) == CNT_MAX))
    else $error("totals did not advance");

endmodule

### rtl/core/fully_assoc_lru_cache_tags.sv
// Fully associative tag store with least recently used replacement.
// lookup_i carries one tag per transaction (valid/ready); result_o returns
// one transaction per lookup with hit, line used, eviction flag and tag, and
// saturating hit and miss totals. cfg_we_i/cfg_wdata_i write the number of
// active lines (0 acts as 1, above NUM_LINES acts as NUM_LINES); write it
// only while no lookup is in flight.
// The tag is registered on acceptance, compared in the lookup state and
// committed to the output register when the tag hits, a free line exists
// or only one line is active; otherwise the least recently used line is
// found first by a one-line-per-cycle stamp scan over the active lines.
// A new lookup is taken only once the previous one has been committed to
// the output register.
// Reset clears all valid bits, stamps, the access clock and the totals, and
// sets the active line count to 16; no clearing pass is needed.
// The result sits in an output register; a new lookup is accepted while it
// waits, and a finished lookup holds its commit until the receiver takes
// the previous result.
module fully_assoc_lru_cache_tags
  import falc_pkg::*;
#(
  parameter int unsigned NUM_LINES = 16,
  parameter int unsigned TAG_BITS  = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i,
  falc_lookup_if.sink        lookup_i,
  falc_result_if.source      result_o
);

  logic [CFG_W-1:0] active_blocks_q;
  falc_cmd_t        cmd;
  falc_status_t     status;

  // active line count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_blocks_q <= ACTIVE_BLOCKS_RST;
    end else if (cfg_we_i) begin
      active_blocks_q <= cfg_wdata_i;
    end
  end

  // sequencing
  falc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (lookup_i.valid),
    .in_ready_o (lookup_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // tag store, stamps, counters and result register
  falc_datapath #(
    .NUM_LINES (NUM_LINES),
    .TAG_BITS  (TAG_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .active_blocks_i   (active_blocks_q),
    .lookup_tag_i      (lookup_i.lookup_tag),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_ready_i       (result_o.ready),
    .out_valid_o       (result_o.valid),
    .res_hit_o         (result_o.hit),
    .res_line_used_o   (result_o.line_used),
    .res_evicted_o     (result_o.evicted),
    .res_evicted_tag_o (result_o.evicted_tag),
    .res_hit_total_o   (result_o.hit_total),
    .res_miss_total_o  (result_o.miss_total)
  );

endmodule

### verif/fully_assoc_lru_cache_tags_test.sv
`timescale 1ns / 1ps

module fully_assoc_lru_cache_tags_test;
  import falc_pkg::*;

  localparam int unsigned LINES = 16;
  localparam int unsigned TAG_POOL = 32;

  typedef struct packed {
    logic                    hit;
    logic [LINE_USED_W-1:0]  line_used;
    logic                    evicted;
    logic [LOOKUP_TAG_W-1:0] evicted_tag;
    logic [CNT_W-1:0]        hit_total;
    logic [CNT_W-1:0]        miss_total;
  } access_result_t;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  falc_lookup_if lookup_ch ();
  falc_result_if result_ch ();

  fully_assoc_lru_cache_tags dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .lookup_i    (lookup_ch),
    .result_o    (result_ch)
  );

  // shadow copy of the tag store
  bit                    line_valid_q [LINES];
  bit [LOOKUP_TAG_W-1:0] line_tag_q   [LINES];
  bit [CNT_W-1:0]        line_stamp_q [LINES];
  bit [CNT_W-1:0]        access_count_q;
  bit [CNT_W-1:0]        hit_count_q;
  bit [CNT_W-1:0]        miss_count_q;
  bit [CFG_W-1:0]        active_blocks_q;

  access_result_t        pending_results [$];
  bit [LOOKUP_TAG_W-1:0] tag_pool [TAG_POOL];

  int unsigned lookups_sent;
  int unsigned results_seen;
  int unsigned mismatch_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_off_left;

  // clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // run limit
  initial begin
    #2_000_000;
    $display("fully_assoc_lru_cache_tags: mismatch");
    $finish;
  end

  function automatic bit [CNT_W-1:0] sat_inc(bit [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // next state of the tag store and the result of one access
  function automatic access_result_t predict_access(bit [LOOKUP_TAG_W-1:0] tag);
    access_result_t res;
    int unsigned    n;
    int unsigned    line;
    bit             hit;
    bit             free_found;
    res        = '0;
    hit        = 1'b0;
    free_found = 1'b0;
    line       = 0;
    n = (active_blocks_q == 0) ? 1 : (active_blocks_q > LINES) ? LINES : active_blocks_q;

    // parallel compare over the active lines
    for (int i = 0; i < n; i++) begin
      if (!hit && line_valid_q[i] && line_tag_q[i] == tag) begin
        hit  = 1'b1;
        line = i;
      end
    end

    if (hit) begin
      hit_count_q = sat_inc(hit_count_q);
    end else begin
      // lowest free line first, else oldest stamp
      for (int i = 0; i < n; i++) begin
        if (!free_found && !line_valid_q[i]) begin
          free_found = 1'b1;
          line       = i;
        end
      end
      if (!free_found) begin
        line = 0;
        for (int i = 1; i < n; i++) begin
          if (line_stamp_q[i] < line_stamp_q[line]) line = i;
        end
        res.evicted     = 1'b1;
        res.evicted_tag = line_tag_q[line];
      end
      line_valid_q[line] = 1'b1;
      line_tag_q[line]   = tag;
      miss_count_q       = sat_inc(miss_count_q);
    end

    line_stamp_q[line] = access_count_q;
    access_count_q     = sat_inc(access_count_q);

    res.hit        = hit;
    res.line_used  = line[LINE_USED_W-1:0];
    res.hit_total  = hit_count_q;
    res.miss_total = miss_count_q;
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // result checking and prediction of accepted lookups
  always @(posedge clk_i) begin
    access_result_t want;
    if (rst_ni) begin
      if (result_ch.valid && result_ch.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("result transaction with no lookup outstanding");
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("hit", 32'(want.hit), 32'(result_ch.hit));
          check_field("line_used", 32'(want.line_used), 32'(result_ch.line_used));
          check_field("evicted", 32'(want.evicted), 32'(result_ch.evicted));
          check_field("evicted_tag", want.evicted_tag, result_ch.evicted_tag);
          check_field("hit_total", want.hit_total, result_ch.hit_total);
          check_field("miss_total", want.miss_total, result_ch.miss_total);
        end
      end
      if (lookup_ch.valid && lookup_ch.ready)
        pending_results.push_back(predict_access(lookup_ch.lookup_tag));
    end
  end

  // receiver: random stalls, or a counted hold-off
  always @(posedge clk_i) begin
    if (hold_off_left != 0) begin
      result_ch.ready <= 1'b0;
      hold_off_left   <= hold_off_left - 1;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic set_idling(idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct  = 53;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct  = 0;
        recv_stall_pct = 53;
      end
      default: begin
        send_idle_pct  = 14;
        recv_stall_pct = 14;
      end
    endcase
  endtask

  // one lookup transaction; valid stays high for a back-to-back follower
  task automatic send_lookup(bit [LOOKUP_TAG_W-1:0] tag);
    while ($urandom_range(99) < send_idle_pct) begin
      lookup_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    lookup_ch.valid      <= 1'b1;
    lookup_ch.lookup_tag <= tag;
    do @(posedge clk_i); while (!lookup_ch.ready);
    lookups_sent++;
  endtask

  // stop sending and wait for every outstanding result
  task automatic wait_drain();
    lookup_ch.valid <= 1'b0;
    do @(posedge clk_i); while (results_seen != lookups_sent);
  endtask

  // register write while the block is idle
  task automatic write_active_blocks(bit [CFG_W-1:0] value);
    wait_drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i        <= 1'b0;
    active_blocks_q  = value;
  endtask

  // mostly tags from a small working set, with some fresh ones
  function automatic bit [LOOKUP_TAG_W-1:0] pick_tag(int unsigned window);
    int unsigned r;
    int unsigned k;
    r = $urandom_range(99);
    if (r < 12) return $urandom();
    k = $urandom_range((window < TAG_POOL) ? window - 1 : TAG_POOL - 1);
    if (r < 16) tag_pool[k] = $urandom();
    return tag_pool[k];
  endfunction

  function automatic int unsigned working_set();
    if (active_blocks_q == 0) return 3;
    if (active_blocks_q > LINES) return LINES + 3;
    return active_blocks_q + 3;
  endfunction

  // extremes of the tag, hits, shrinking and regrowing the active range
  task automatic test_directed_lookups();
    set_idling(IDLE_NONE);
    send_lookup(32'h0000_0000);
    send_lookup(32'hFFFF_FFFF);
    send_lookup(32'h5555_5555);
    send_lookup(32'hAAAA_AAAA);
    send_lookup(32'h0000_0000);
    // zero acts as one line; line 1 is out of range, so no hit
    write_active_blocks(5'd0);
    send_lookup(32'hFFFF_FFFF);
    send_lookup(32'h0000_0000);
    send_lookup(32'h0000_0000);
    // above the line count acts as all lines; retained lines hit again
    write_active_blocks(5'd31);
    send_lookup(32'hFFFF_FFFF);
    send_lookup(32'h5555_5555);
    send_lookup(32'hAAAA_AAAA);
    // two lines full, least recently used goes first
    write_active_blocks(5'd2);
    send_lookup(32'h0000_0001);
    send_lookup(32'h8000_0000);
    send_lookup(32'h0000_0001);
    send_lookup(32'h7FFF_FFFE);
    write_active_blocks(5'd1);
    send_lookup(32'h1234_5678);
    send_lookup(32'h1234_5678);
    wait_drain();
  endtask

  // random lookups across several active sizes and idling patterns
  task automatic test_random_phases();
    bit [CFG_W-1:0] sizes [8];
    sizes = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd6, 5'd2, 5'd17, 5'd11};
    for (int p = 0; p < 8; p++) begin
      write_active_blocks(sizes[p]);
      set_idling(idle_mode_e'(p % 4));
      for (int i = 0; i < 80; i++) send_lookup(pick_tag(working_set()));
    end
    wait_drain();
  endtask

  // receiver holds off long enough for the input to back up
  task automatic test_output_hold_off();
    write_active_blocks(5'd8);
    set_idling(IDLE_NONE);
    @(posedge clk_i);
    hold_off_left = 80;
    for (int i = 0; i < 30; i++) send_lookup(pick_tag(working_set()));
    wait_drain();
  endtask

  // sender pauses until all results are back, then resumes
  task automatic test_drain_pause();
    write_active_blocks(5'd16);
    set_idling(IDLE_BOTH);
    for (int i = 0; i < 10; i++) send_lookup(pick_tag(working_set()));
    wait_drain();
    for (int i = 0; i < 10; i++) send_lookup(pick_tag(working_set()));
    wait_drain();
  endtask

  initial begin
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_wdata_i          = '0;
    lookup_ch.valid      = 1'b0;
    lookup_ch.lookup_tag = '0;
    result_ch.ready      = 1'b0;
    send_idle_pct        = 0;
    recv_stall_pct       = 0;
    hold_off_left        = 0;
    lookups_sent         = 0;
    results_seen         = 0;
    mismatch_count       = 0;

    // predictor state after reset
    for (int i = 0; i < LINES; i++) begin
      line_valid_q[i] = 1'b0;
      line_tag_q[i]   = '0;
      line_stamp_q[i] = '0;
    end
    access_count_q  = '0;
    hit_count_q     = '0;
    miss_count_q    = '0;
    active_blocks_q = ACTIVE_BLOCKS_RST;
    for (int i = 0; i < TAG_POOL; i++) tag_pool[i] = $urandom();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_lookups();
    test_random_phases();
    test_output_hold_off();
    test_drain_pause();

    // let any stray result show up
    wait_drain();
    repeat (40) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d lookups never returned a result", pending_results.size());
      mismatch_count++;
    end

    if (mismatch_count == 0) begin
      $display("fully_assoc_lru_cache_tags: match");
    end else begin
      $display("fully_assoc_lru_cache_tags: mismatch");
    end
    $finish;
  end

endmodule
